/* design/unsorted_array_list_core_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the unordered list core
// Shorthand for clocked concurrent assertions, with and without reset masking.
// ---------------------------------------------------------------------------
`ifndef UNSORTED_ARRAY_LIST_CORE_MACROS_SVH
`define UNSORTED_ARRAY_LIST_CORE_MACROS_SVH

// The property is checked only while reset is released.
`define UAL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The property is checked at every edge, reset included.
`define UAL_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/ual_pkg.sv */
// ---------------------------------------------------------------------------
// Unordered list package
// Operation and status codes and the fixed field widths of the list core.
// ---------------------------------------------------------------------------
package ual_pkg;

    localparam int VALUE_W = 32;
    localparam int OP_W    = 3;
    localparam int COUNT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 3'd0,
        OP_DELETE   = 3'd1,
        OP_RETRIEVE = 3'd2,
        OP_GET_NEXT = 3'd3,
        OP_RESET    = 3'd4,
        OP_EMPTY    = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_END       = 2'd3
    } t_status;

endpackage

/* design/unsorted_array_list_core.sv */
// ---------------------------------------------------------------------------
// Unordered list core
// Fixed store of unordered entries with append, swap-with-last delete,
// linear search and a read cursor, built around one memory read port.
// ---------------------------------------------------------------------------
//  Channel  Dir  Handshake                 Beat fields
//  in       in   i_in_valid / o_in_stall   i_op, i_item_value
//  out      out  o_out_valid / i_out_stall o_item_out, o_found, o_status,
//                                          o_entry_count, o_is_full
//
// Insert, cursor reset, make empty, unused codes and get next past the end
// go straight to the result register; get next with an entry first captures
// the entry read from memory. Retrieve and delete compare one entry per cycle
// until a hit or the end of the list, and a delete that hits then moves the last entry.
// The input is stalled until the result is in the output register, and a
// stalled output beat holds the block. Reset clears count, cursor and control.
module unsorted_array_list_core #(
    parameter int CAPACITY = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [ual_pkg::OP_W-1:0]      i_op,
    input  logic [ual_pkg::VALUE_W-1:0]   i_item_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ual_pkg::VALUE_W-1:0]   o_item_out,
    output logic                          o_found,
    output logic [1:0]                    o_status,
    output logic [ual_pkg::COUNT_W-1:0]   o_entry_count,
    output logic                          o_is_full
);
    import ual_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_LAST_RD,
        S_LAST_WR,
        S_NEXT_CAP,
        S_RESULT
    } t_state;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_cursor, n_cursor;
    logic [CW-1:0]        r_idx, n_idx;
    logic                 r_cmp_valid, n_cmp_valid;
    logic [AW-1:0]        r_cmp_idx, n_cmp_idx;
    logic [AW-1:0]        r_loc, n_loc;
    logic [VALUE_W-1:0]   r_value, n_value;
    logic                 r_is_del, n_is_del;
    logic [VALUE_W-1:0]   r_res_item, n_res_item;
    logic                 r_res_found, n_res_found;
    t_status              r_res_status, n_res_status;
    logic                 r_out_valid, n_out_valid;
    logic [VALUE_W-1:0]   r_out_item, n_out_item;
    logic                 r_out_found, n_out_found;
    t_status              r_out_status, n_out_status;
    logic [COUNT_W-1:0]   r_out_count, n_out_count;
    logic                 r_out_full, n_out_full;

    logic [VALUE_W-1:0]   r_mem [CAPACITY];
    logic [VALUE_W-1:0]   r_rdata;
    logic [AW-1:0]        w_rd_addr;
    logic                 w_wr_en;
    logic [AW-1:0]        w_wr_addr;
    logic [VALUE_W-1:0]   w_wr_data;

    logic                 w_accept;
    logic                 w_out_free;
    logic [CW-1:0]        w_last_idx;
    logic [CW+COUNT_W-1:0] w_count_ext;

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_last_idx  = r_count - CW'(1);
    assign w_count_ext = {{COUNT_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_cursor     = r_cursor;
        n_idx        = r_idx;
        n_cmp_valid  = r_cmp_valid;
        n_cmp_idx    = r_cmp_idx;
        n_loc        = r_loc;
        n_value      = r_value;
        n_is_del     = r_is_del;
        n_res_item   = r_res_item;
        n_res_found  = r_res_found;
        n_res_status = r_res_status;
        n_out_item   = r_out_item;
        n_out_found  = r_out_found;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        n_out_full   = r_out_full;
        n_out_valid  = r_out_valid && i_out_stall;
        w_rd_addr    = r_cursor[AW-1:0];
        w_wr_en      = 1'b0;
        w_wr_addr    = r_count[AW-1:0];
        w_wr_data    = i_item_value;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res_item   = '0;
                    n_res_found  = 1'b0;
                    n_res_status = ST_OK;
                    n_state      = S_RESULT;
                    unique case (i_op)
                        OP_INSERT: begin
                            if (r_count == CW'(CAPACITY)) begin
                                n_res_status = ST_FULL;
                            end else begin
                                w_wr_en = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        OP_DELETE, OP_RETRIEVE: begin
                            n_value     = i_item_value;
                            n_is_del    = (i_op == OP_DELETE);
                            n_idx       = '0;
                            n_cmp_valid = 1'b0;
                            n_state     = S_SEARCH;
                        end
                        OP_GET_NEXT: begin
                            if (r_cursor < r_count) begin
                                n_state = S_NEXT_CAP;
                            end else begin
                                n_res_status = ST_END;
                            end
                        end
                        OP_RESET: begin
                            n_cursor = '0;
                        end
                        OP_EMPTY: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                w_rd_addr = r_idx[AW-1:0];
                if (r_cmp_valid && (r_rdata == r_value)) begin
                    n_cmp_valid = 1'b0;
                    n_loc       = r_cmp_idx;
                    n_res_found = 1'b1;
                    if (r_is_del) begin
                        n_state = S_LAST_RD;
                    end else begin
                        n_res_item = r_value;
                        n_state    = S_RESULT;
                    end
                end else if (r_idx < r_count) begin
                    n_idx       = r_idx + CW'(1);
                    n_cmp_valid = 1'b1;
                    n_cmp_idx   = r_idx[AW-1:0];
                end else begin
                    n_cmp_valid = 1'b0;
                    if (!r_cmp_valid) begin
                        n_res_status = ST_NOT_FOUND;
                        n_state      = S_RESULT;
                    end
                end
            end
            S_LAST_RD: begin
                w_rd_addr = w_last_idx[AW-1:0];
                n_state   = S_LAST_WR;
            end
            S_LAST_WR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_loc;
                w_wr_data = r_rdata;
                n_count   = w_last_idx;
                n_state   = S_RESULT;
            end
            S_NEXT_CAP: begin
                n_res_item = r_rdata;
                n_cursor   = r_cursor + CW'(1);
                n_state    = S_RESULT;
            end
            S_RESULT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_item   = r_res_item;
                    n_out_found  = r_res_found;
                    n_out_status = r_res_status;
                    n_out_count  = w_count_ext[COUNT_W-1:0];
                    n_out_full   = (r_count == CW'(CAPACITY));
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cursor    <= '0;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cursor    <= n_cursor;
            r_cmp_valid <= n_cmp_valid;
            r_out_valid <= n_out_valid;
        end
        r_idx        <= n_idx;
        r_cmp_idx    <= n_cmp_idx;
        r_loc        <= n_loc;
        r_value      <= n_value;
        r_is_del     <= n_is_del;
        r_res_item   <= n_res_item;
        r_res_found  <= n_res_found;
        r_res_status <= n_res_status;
        r_out_item   <= n_out_item;
        r_out_found  <= n_out_found;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
        r_out_full   <= n_out_full;
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_item_out    = r_out_item;
    assign o_found       = r_out_found;
    assign o_status      = r_out_status;
    assign o_entry_count = r_out_count;
    assign o_is_full     = r_out_full;

endmodule

/* design/ual_checker.sv */
// ---------------------------------------------------------------------------
// Unordered list port checker
// Watches the list core's ports for handshake and result consistency.
// ---------------------------------------------------------------------------
`include "unsorted_array_list_core_macros.svh"

module ual_checker #(
    parameter int CAPACITY = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic [ual_pkg::OP_W-1:0]      i_op,
    input logic [ual_pkg::VALUE_W-1:0]   i_item_value,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [ual_pkg::VALUE_W-1:0]   o_item_out,
    input logic                          o_found,
    input logic [1:0]                    o_status,
    input logic [ual_pkg::COUNT_W-1:0]   o_entry_count,
    input logic                          o_is_full
);
    import ual_pkg::*;

    localparam logic [COUNT_W-1:0] CAP_CNT = COUNT_W'(CAPACITY);

    `UAL_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")
    `UAL_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_item_out) && $stable(o_status) && $stable(o_entry_count), "stalled output beat changed")
    `UAL_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> o_in_stall, "input not stalled while a beat is in work")
    `UAL_ASSERT(a_full_count, i_clk, i_rst_n, o_out_valid && o_is_full |-> o_entry_count == CAP_CNT, "full flag without full count")
    `UAL_ASSERT(a_found_ok, i_clk, i_rst_n, o_out_valid && o_found |-> o_status == ST_OK && !(o_status == ST_FULL), "match reported with a failing status")

endmodule

bind unsorted_array_list_core ual_checker #(.CAPACITY(CAPACITY)) u_ual_checker (.*);

/* test/unsorted_array_list_core_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Unordered list core checker
// Watches both channels of the list core and keeps its own copy of the list,
// count and cursor. Every request beat accepted on the input produces one
// expected result, and every result beat accepted on the output is compared
// field by field with the oldest expected one.
// ---------------------------------------------------------------------------
module unsorted_array_list_core_checker #(
    parameter int DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [ual_pkg::OP_W-1:0]      i_op,
    input  logic [ual_pkg::VALUE_W-1:0]   i_item_value,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [ual_pkg::VALUE_W-1:0]   i_item_out,
    input  logic                          i_found,
    input  logic [1:0]                    i_status,
    input  logic [ual_pkg::COUNT_W-1:0]   i_entry_count,
    input  logic                          i_is_full,
    output int                            o_fail_count,
    output int                            o_pending
);
    import ual_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef struct packed {
        logic [VALUE_W-1:0] item;
        logic               found;
        t_status            status;
        logic [COUNT_W-1:0] count;
        logic               full;
    } t_list_result;

    logic [VALUE_W-1:0] list_entries [DEPTH];
    int                 list_count;
    int                 list_cursor;
    t_list_result       result_q [$];
    int                 fails = 0;

    assign o_fail_count = fails;

    function automatic t_list_result apply_request(logic [OP_W-1:0] op,
                                                   logic [VALUE_W-1:0] value);
        t_list_result res;
        int           slot;
        res = '0;
        res.status = ST_OK;
        slot = -1;
        for (int i = 0; i < list_count; i++) begin
            if (slot < 0 && list_entries[IDX_W'(i)] == value) begin
                slot = i;
            end
        end
        case (op)
            OP_INSERT: begin
                if (list_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    list_entries[IDX_W'(list_count)] = value;
                    list_count++;
                end
            end
            OP_DELETE: begin
                if (slot >= 0) begin
                    list_entries[IDX_W'(slot)] = list_entries[IDX_W'(list_count - 1)];
                    list_count--;
                    res.found = 1'b1;
                end else begin
                    res.status = ST_NOT_FOUND;
                end
            end
            OP_RETRIEVE: begin
                if (slot >= 0) begin
                    res.item  = list_entries[IDX_W'(slot)];
                    res.found = 1'b1;
                end else begin
                    res.status = ST_NOT_FOUND;
                end
            end
            OP_GET_NEXT: begin
                if (list_cursor < list_count) begin
                    res.item = list_entries[IDX_W'(list_cursor)];
                    list_cursor++;
                end else begin
                    res.status = ST_END;
                end
            end
            OP_RESET: list_cursor = 0;
            OP_EMPTY: list_count = 0;
            default: ;
        endcase
        res.count = COUNT_W'(list_count);
        res.full  = (list_count == DEPTH);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                               input logic [VALUE_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_list_result want;
        if (!i_rst_n) begin
            list_count  = 0;
            list_cursor = 0;
            result_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    $display("%0t: result beat with none expected, got item %h status %h",
                             $time, i_item_out, i_status);
                    fails++;
                end else begin
                    want = result_q.pop_front();
                    check_field("item_out", want.item, i_item_out);
                    check_field("found", VALUE_W'(want.found), VALUE_W'(i_found));
                    check_field("status", VALUE_W'(want.status), VALUE_W'(i_status));
                    check_field("entry_count", VALUE_W'(want.count),
                                VALUE_W'(i_entry_count));
                    check_field("is_full", VALUE_W'(want.full), VALUE_W'(i_is_full));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                result_q.push_back(apply_request(i_op, i_item_value));
            end
        end
        o_pending <= result_q.size();
    end

endmodule

/* test/unsorted_array_list_core_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Unordered list core testbench
// Drives a short directed sequence covering the value extremes, every
// operation, a full list and the not-found and end-of-list cases, then
// random requests in phases with and without sender gaps and output stalls.
// The checker beside the core predicts and compares each result beat.
// ---------------------------------------------------------------------------
module unsorted_array_list_core_tb;
    import ual_pkg::*;

    localparam int              LIST_DEPTH   = 16;
    localparam int              PHASE_ITEMS  = 382;
    localparam logic [OP_W-1:0] OP_SPARE_6   = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7   = 3'd7;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_in_valid   = 1'b0;
    logic [OP_W-1:0]    i_op         = '0;
    logic [VALUE_W-1:0] i_item_value = '0;
    logic               i_out_stall  = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [VALUE_W-1:0] o_item_out;
    logic               o_found;
    logic [1:0]         o_status;
    logic [COUNT_W-1:0] o_entry_count;
    logic               o_is_full;
    int                 fail_count;
    int                 pending;

    int                 idle_pct  = 0;
    int                 stall_pct = 0;
    logic [VALUE_W-1:0] value_pool [8];

    unsorted_array_list_core #(
        .CAPACITY(LIST_DEPTH)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_op(i_op),
        .i_item_value(i_item_value),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_item_out(o_item_out),
        .o_found(o_found),
        .o_status(o_status),
        .o_entry_count(o_entry_count),
        .o_is_full(o_is_full)
    );

    unsorted_array_list_core_checker #(
        .DEPTH(LIST_DEPTH)
    ) u_checker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .i_in_stall(o_in_stall),
        .i_op(i_op),
        .i_item_value(i_item_value),
        .i_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_item_out(o_item_out),
        .i_found(o_found),
        .i_status(o_status),
        .i_entry_count(o_entry_count),
        .i_is_full(o_is_full),
        .o_fail_count(fail_count),
        .o_pending(pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_request(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_item_value <= value;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_random(input int seq_no);
        int                 insert_pct;
        int                 pick;
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        insert_pct = ((seq_no / 64) % 2 == 0) ? 55 : 20;
        pick = $urandom_range(99);
        if (pick < insert_pct) begin
            op = OP_INSERT;
        end else begin
            pick = $urandom_range(99);
            if (pick < 28) begin
                op = OP_DELETE;
            end else if (pick < 56) begin
                op = OP_RETRIEVE;
            end else if (pick < 80) begin
                op = OP_GET_NEXT;
            end else if (pick < 90) begin
                op = OP_RESET;
            end else if (pick < 95) begin
                op = OP_EMPTY;
            end else begin
                op = $urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7;
            end
        end
        value = ($urandom_range(3) != 0) ? value_pool[$urandom_range(7)] : $urandom();
        send_request(op, value);
    endtask

    task automatic run_phase(input int idle, input int stall);
        idle_pct  = idle;
        stall_pct = stall;
        for (int i = 0; i < 8; i++) begin
            value_pool[i] = $urandom();
        end
        value_pool[0] = '0;
        value_pool[7] = '1;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_random(n);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(OP_INSERT, '0);
        send_request(OP_INSERT, '1);
        for (int i = 0; i < LIST_DEPTH - 2; i++) begin
            send_request(OP_INSERT, $urandom());
        end
        send_request(OP_INSERT, 32'h5A5A_A5A5);
        send_request(OP_RETRIEVE, '1);
        send_request(OP_RETRIEVE, 32'h5A5A_A5A5);
        send_request(OP_DELETE, '0);
        send_request(OP_DELETE, 32'h5A5A_A5A5);
        send_request(OP_GET_NEXT, '0);
        send_request(OP_EMPTY, '0);
        send_request(OP_GET_NEXT, '0);
        send_request(OP_RESET, '0);
        send_request(OP_SPARE_6, '1);
        send_request(OP_SPARE_7, '0);

        run_phase(0, 0);
        run_phase(61, 0);
        run_phase(0, 61);
        run_phase(28, 28);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
